// ===== hw/rtl/cds_pkg.sv =====
`default_nettype none

package cds_pkg;

	localparam int unsigned DeltaW = 10;
	localparam int unsigned RegW   = 17;
	localparam int unsigned TimeW  = 18;
	localparam int unsigned ModeW  = 3;
	localparam int unsigned DriveW = 2;
	localparam int unsigned IdxW   = 2;

	localparam logic [TimeW-1:0] TIME_MAX = {TimeW{1'b1}};

	// Mode codes.
	localparam logic [ModeW-1:0] MODE_READY    = 3'd0;
	localparam logic [ModeW-1:0] MODE_OPENING  = 3'd1;
	localparam logic [ModeW-1:0] MODE_SPILLING = 3'd2;
	localparam logic [ModeW-1:0] MODE_CLOSING  = 3'd3;
	localparam logic [ModeW-1:0] MODE_RECEIVED = 3'd4;
	localparam logic [ModeW-1:0] MODE_SLEEPING = 3'd5;
	localparam logic [ModeW-1:0] MODE_FULL     = 3'd6;
	localparam logic [ModeW-1:0] MODE_MAINT    = 3'd7;

	// Door motor drive codes.
	localparam logic [DriveW-1:0] DRIVE_OFF   = 2'd0;
	localparam logic [DriveW-1:0] DRIVE_OPEN  = 2'd1;
	localparam logic [DriveW-1:0] DRIVE_CLOSE = 2'd2;

	// Configuration register indexes.
	localparam logic [IdxW-1:0] REG_DOOR_TRAVEL   = 2'd0;
	localparam logic [IdxW-1:0] REG_SPILL_LIMIT   = 2'd1;
	localparam logic [IdxW-1:0] REG_RECEIVED_HOLD = 2'd2;
	localparam logic [IdxW-1:0] REG_IDLE_SLEEP    = 2'd3;

	// Register reset values.
	localparam logic [RegW-1:0] DOOR_TRAVEL_RST   = 17'd1000;
	localparam logic [RegW-1:0] SPILL_LIMIT_RST   = 17'd20000;
	localparam logic [RegW-1:0] RECEIVED_HOLD_RST = 17'd2000;
	localparam logic [RegW-1:0] IDLE_SLEEP_RST    = 17'd120000;

	typedef struct packed {
		logic [RegW-1:0] door_travel_ms;
		logic [RegW-1:0] spill_limit_ms;
		logic [RegW-1:0] received_hold_ms;
		logic [RegW-1:0] idle_sleep_ms;
	} cds_cfg_t;

	typedef struct packed {
		logic [DeltaW-1:0] delta_ms;
		logic              open_pressed;
		logic              close_pressed;
		logic              container_full;
		logic              maintenance_mode;
	} cds_tick_t;

	typedef struct packed {
		logic [ModeW-1:0]  mode;
		logic              mode_entered;
		logic [DriveW-1:0] door_drive;
		logic              sleep_request;
	} cds_result_t;

	typedef struct packed {
		logic [ModeW-1:0] mode;
		logic [TimeW-1:0] elapsed;
		logic             entry_pending;
	} cds_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cds_chan_if.sv =====
`default_nettype none

interface cds_tick_if import cds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DeltaW-1:0] delta_ms;
	logic              open_pressed;
	logic              close_pressed;
	logic              container_full;
	logic              maintenance_mode;

	modport source (output valid, delta_ms, open_pressed, close_pressed,
		container_full, maintenance_mode, input ready);
	modport sink (input valid, delta_ms, open_pressed, close_pressed,
		container_full, maintenance_mode, output ready);
endinterface

interface cds_result_if import cds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ModeW-1:0]  mode;
	logic              mode_entered;
	logic [DriveW-1:0] door_drive;
	logic              sleep_request;

	modport source (output valid, mode, mode_entered, door_drive, sleep_request,
		input ready);
	modport sink (input valid, mode, mode_entered, door_drive, sleep_request,
		output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cds_cfg_regs.sv =====
`default_nettype none

module cds_cfg_regs import cds_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_wr_en,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [RegW-1:0] cfg_data,
	output cds_cfg_t             cfg
);

	cds_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.door_travel_ms   <= DOOR_TRAVEL_RST;
			cfg_q.spill_limit_ms   <= SPILL_LIMIT_RST;
			cfg_q.received_hold_ms <= RECEIVED_HOLD_RST;
			cfg_q.idle_sleep_ms    <= IDLE_SLEEP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DOOR_TRAVEL:   cfg_q.door_travel_ms   <= cfg_data;
				REG_SPILL_LIMIT:   cfg_q.spill_limit_ms   <= cfg_data;
				REG_RECEIVED_HOLD: cfg_q.received_hold_ms <= cfg_data;
				REG_IDLE_SLEEP:    cfg_q.idle_sleep_ms    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cds_step.sv =====
`default_nettype none

// One tick of the mode sequencer: counter update, maintenance override,
// then one pass of the active mode's behavior.
module cds_step import cds_pkg::*; (
	input  cds_cfg_t    cfg,
	input  cds_tick_t   tick,
	input  cds_state_t  cur,
	output cds_state_t  nxt,
	output cds_result_t res
);

	logic [TimeW:0]    sum;
	logic [TimeW-1:0]  sat;
	logic [TimeW-1:0]  t;
	logic [ModeW-1:0]  ran;
	logic              entered;
	logic              move;
	logic [ModeW-1:0]  target;
	logic [DriveW-1:0] drive;
	logic              sleep_req;
	logic              over_travel;
	logic              over_spill;
	logic              over_hold;
	logic              over_idle;

	always_comb begin
		sum = {1'b0, cur.elapsed} + {{(TimeW + 1 - DeltaW){1'b0}}, tick.delta_ms};
		sat = sum[TimeW] ? TIME_MAX : sum[TimeW-1:0];

		// Maintenance takes over at once and runs in this same tick.
		if (tick.maintenance_mode && (cur.mode != MODE_MAINT)) begin
			ran     = MODE_MAINT;
			t       = '0;
			entered = 1'b1;
		end else begin
			ran     = cur.mode;
			t       = sat;
			entered = cur.entry_pending;
		end

		over_travel = t > {1'b0, cfg.door_travel_ms};
		over_spill  = t > {1'b0, cfg.spill_limit_ms};
		over_hold   = t > {1'b0, cfg.received_hold_ms};
		over_idle   = t > {1'b0, cfg.idle_sleep_ms};

		move      = 1'b0;
		target    = MODE_READY;
		drive     = DRIVE_OFF;
		sleep_req = 1'b0;

		case (ran)
			MODE_READY: begin
				if (tick.open_pressed) begin
					move   = 1'b1;
					target = MODE_OPENING;
				end else if (over_idle && !tick.container_full) begin
					move   = 1'b1;
					target = MODE_SLEEPING;
				end
			end
			MODE_OPENING: begin
				if (over_travel) begin
					move   = 1'b1;
					target = MODE_SPILLING;
				end else begin
					drive = DRIVE_OPEN;
				end
			end
			MODE_SPILLING: begin
				if (tick.close_pressed || over_spill || tick.container_full) begin
					move   = 1'b1;
					target = MODE_CLOSING;
				end
			end
			MODE_CLOSING: begin
				if (over_travel) begin
					move   = 1'b1;
					target = MODE_RECEIVED;
				end else begin
					drive = DRIVE_CLOSE;
				end
			end
			MODE_RECEIVED: begin
				if (over_hold) begin
					move   = 1'b1;
					target = tick.container_full ? MODE_FULL : MODE_READY;
				end
			end
			MODE_SLEEPING: begin
				sleep_req = 1'b1;
				move      = 1'b1;
				target    = MODE_READY;
			end
			MODE_FULL: begin
				if (!tick.container_full) begin
					move   = 1'b1;
					target = MODE_READY;
				end
			end
			default: begin
				if (!tick.maintenance_mode) begin
					move   = 1'b1;
					target = MODE_READY;
				end
			end
		endcase

		if (move) begin
			nxt.mode          = target;
			nxt.elapsed       = '0;
			nxt.entry_pending = 1'b1;
		end else begin
			nxt.mode          = ran;
			nxt.elapsed       = t;
			nxt.entry_pending = 1'b0;
		end

		res.mode          = ran;
		res.mode_entered  = entered;
		res.door_drive    = drive;
		res.sleep_request = sleep_req;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/container_door_sequencer.sv =====
`default_nettype none

// Channel   Dir  Payload                                              Beat
// --------  ---  ---------------------------------------------------  ----------------
// ticks     in   delta_ms[9:0], open/close pressed, full, maintenance  valid & ready
// results   out  mode[2:0], mode_entered, door_drive[1:0], sleep_req   valid & ready
// cfg       in   cfg_index[1:0], cfg_data[16:0]                        cfg_wr_en
//
// A tick beat lands in the input register, and one pass of the mode logic then
// fills the result register; one tick every cycle while results are not stalled.
// Mode, time-in-mode counter and entry flag update on the edge that loads the result.
// A stalled result holds both registers; ticks.ready drops only when both are full.
// Reset restores ready mode, a zero counter, an armed entry flag and the
// default limits, and empties both registers.
module container_door_sequencer import cds_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	cds_tick_if.sink             ticks,
	cds_result_if.source         results,
	input  wire logic            cfg_wr_en,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [RegW-1:0] cfg_data
);

	cds_cfg_t    cfg;
	cds_tick_t   tick_s1;
	logic        tick_valid_s1;
	cds_state_t  state_q;
	cds_state_t  state_nxt;
	cds_result_t res_nxt;
	cds_result_t res_q;
	logic        res_valid_q;
	logic        step_fire;
	logic        tick_beat;

	// Limits live in their own register bank; the user must change them only while idle (not enforced here).
	cds_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The held tick moves into the result register when that register is
	// empty or its beat is being taken this cycle.
	assign step_fire    = tick_valid_s1 && (!res_valid_q || results.ready);
	assign ticks.ready  = !tick_valid_s1 || step_fire;
	assign tick_beat    = ticks.valid && ticks.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (ticks.ready) begin
			tick_valid_s1 <= ticks.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_beat) begin
			tick_s1.delta_ms         <= ticks.delta_ms;
			tick_s1.open_pressed     <= ticks.open_pressed;
			tick_s1.close_pressed    <= ticks.close_pressed;
			tick_s1.container_full   <= ticks.container_full;
			tick_s1.maintenance_mode <= ticks.maintenance_mode;
		end
	end

	cds_step u_step (
		.cfg  (cfg),
		.tick (tick_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Sequencer state advances exactly once per tick, together with the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_READY;
			state_q.elapsed       <= '0;
			state_q.entry_pending <= 1'b1;
		end else if (step_fire) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_fire) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			res_q <= res_nxt;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.mode          = res_q.mode;
	assign results.mode_entered  = res_q.mode_entered;
	assign results.door_drive    = res_q.door_drive;
	assign results.sleep_request = res_q.sleep_request;

endmodule

`default_nettype wire

// ===== hw/rtl/cds_checker.sv =====
`default_nettype none

module cds_checker import cds_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic [ModeW-1:0]  res_mode,
	input wire logic              res_entered,
	input wire logic [DriveW-1:0] res_drive,
	input wire logic              res_sleep
);

	// A result beat that is not taken stays offered.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	// A stalled result keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable({res_mode, res_entered, res_drive, res_sleep}))
		else $error("result payload changed while stalled");

	// The motor only runs in the opening and closing modes, in its own direction.
	a_drive_mode: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_drive == DRIVE_OFF)
			|| (res_drive == DRIVE_OPEN && res_mode == MODE_OPENING)
			|| (res_drive == DRIVE_CLOSE && res_mode == MODE_CLOSING))
		else $error("door drive does not match mode");

	// Sleeping lasts one tick, so a sleep request is always its first tick.
	a_sleep_entry: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_sleep |-> res_mode == MODE_SLEEPING && res_entered)
		else $error("sleep request outside a fresh sleeping tick");

endmodule

bind container_door_sequencer cds_checker u_cds_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (results.valid),
	.res_ready   (results.ready),
	.res_mode    (results.mode),
	.res_entered (results.mode_entered),
	.res_drive   (results.door_drive),
	.res_sleep   (results.sleep_request)
);

`default_nettype wire
